FILE: src/otm_pkg.sv
// Shared types, codes and sizes for the overdue timer table.
package otm_pkg;

  localparam int CAPACITY = 16;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 32;
  localparam int ID_W     = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TICK   = 2'd1,
    OP_SELECT = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_NONE  = 2'd2,
    STS_NOSEL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_POP_RD,
    S_POP_WR,
    S_OUT_RD,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   effect;
    logic [ID_W-1:0]   entity;
    logic [TIME_W-1:0] start;
    logic [DUR_W-1:0]  wait_ticks;
  } entry_t;

  typedef struct packed {
    status_t         status;
    logic            top_valid;
    logic [ID_W-1:0] top_effect_id;
    logic [ID_W-1:0] top_entity_id;
  } res_t;

endpackage

FILE: src/otm_if.sv
// Request and result channel interfaces of the overdue timer table.
interface otm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] effect_id;
  logic [15:0] entity_id;
  logic [31:0] duration;

  modport source (output valid, op, effect_id, entity_id, duration, input ready);
  modport sink   (input valid, op, effect_id, entity_id, duration, output ready);
endinterface

interface otm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        top_valid;
  logic [15:0] top_effect_id;
  logic [15:0] top_entity_id;

  modport source (output valid, status, top_valid, top_effect_id, top_entity_id,
                  input ready);
  modport sink   (input valid, status, top_valid, top_effect_id, top_entity_id,
                  output ready);
endinterface

FILE: src/otm_ram.sv
// Generic single-write, single-read memory with registered read data.
module otm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/otm_late.sv
// Shared lateness unit: elapsed time, overdue amount and compare with the best so far.
module otm_late
  import otm_pkg::*;
(
  input  logic [TIME_W-1:0] now_ticks,
  input  logic [TIME_W-1:0] start,
  input  logic [DUR_W-1:0]  wait_ticks,
  input  logic [TIME_W-1:0] best,
  output logic              better,
  output logic [TIME_W-1:0] late
);

  logic [TIME_W-1:0] elapsed;

  always_comb begin
    elapsed = now_ticks - start;
    late    = elapsed - wait_ticks;
    better  = (elapsed > wait_ticks) && (late > best);
  end

endmodule

FILE: src/otm_seq.sv
// Sequencer of the overdue timer table: ops, scan, compaction and result read.
module otm_seq
  import otm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  otm_in_if.sink     in_ch,
  input  logic       res_ready,
  output logic       res_valid,
  output res_t       res
);

  seq_state_t        state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  chosen_r, chosen_nxt;
  logic              flag_r, flag_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [TIME_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;
  entry_t            rdata;
  logic              better;
  logic [TIME_W-1:0] late;
  logic [CNT_W-1:0]  idx_ext;

  otm_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  otm_late u_late (
    .now_ticks  (now_r),
    .start      (rdata.start),
    .wait_ticks (rdata.wait_ticks),
    .best       (best_r),
    .better     (better),
    .late       (late)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      used_r   <= '0;
      chosen_r <= '0;
      flag_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      used_r   <= used_nxt;
      chosen_r <= chosen_nxt;
      flag_r   <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pend_r     <= pend_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    used_nxt     = used_r;
    chosen_nxt   = chosen_r;
    flag_nxt     = flag_r;
    idx_nxt      = idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    pend_nxt     = pend_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    we           = 1'b0;
    waddr        = idx_r;
    wdata        = rdata;
    raddr        = chosen_r;
    in_ch.ready  = 1'b0;
    res_valid    = 1'b0;
    idx_ext      = {1'b0, idx_r};

    res.status        = status_r;
    res.top_valid     = flag_r && ({1'b0, chosen_r} < used_r);
    res.top_effect_id = res.top_valid ? rdata.effect : '0;
    res.top_entity_id = res.top_valid ? rdata.entity : '0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          status_nxt = STS_OK;
          state_nxt  = S_OUT_RD;
          case (op_t'(in_ch.op))
            OP_ADD: begin
              if (used_r == CNT_W'(CAPACITY)) begin
                status_nxt = STS_FULL;
              end else begin
                we               = 1'b1;
                waddr            = used_r[IDX_W-1:0];
                wdata.effect     = in_ch.effect_id;
                wdata.entity     = in_ch.entity_id;
                wdata.start      = now_r;
                wdata.wait_ticks = in_ch.duration;
                used_nxt         = used_r + 1'b1;
              end
            end
            OP_TICK: begin
              now_nxt = now_r + 1'b1;
            end
            OP_SELECT: begin
              best_nxt  = '0;
              found_nxt = 1'b0;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              if (used_r == '0) begin
                status_nxt = STS_NONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_POP: begin
              if (!flag_r || ({1'b0, chosen_r} >= used_r)) begin
                status_nxt = STS_NOSEL;
              end else begin
                idx_nxt   = chosen_r;
                state_nxt = S_POP_RD;
              end
            end
            default: begin
              status_nxt = STS_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the read of the next entry while judging the previous one.
        raddr       = idx_r;
        pend_nxt    = 1'b1;
        cmp_idx_nxt = idx_r;
        if (pend_r && better) begin
          best_nxt     = late;
          best_idx_nxt = cmp_idx_r;
          found_nxt    = 1'b1;
        end
        if (idx_ext + 1'b1 == used_r) begin
          state_nxt = S_SCAN_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SCAN_LAST: begin
        state_nxt = S_OUT_RD;
        if (found_r || better) begin
          chosen_nxt = better ? cmp_idx_r : best_idx_r;
          flag_nxt   = 1'b1;
          status_nxt = STS_OK;
        end else begin
          status_nxt = STS_NONE;
        end
      end

      S_POP_RD: begin
        if (idx_ext + 1'b1 < used_r) begin
          raddr     = idx_r + 1'b1;
          state_nxt = S_POP_WR;
        end else begin
          used_nxt   = used_r - 1'b1;
          flag_nxt   = 1'b0;
          chosen_nxt = '0;
          status_nxt = STS_OK;
          state_nxt  = S_OUT_RD;
        end
      end

      S_POP_WR: begin
        // Move the following entry down one place.
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_POP_RD;
      end

      S_OUT_RD: begin
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/overdue_timer_table.sv
// Top level of the overdue timer table: sequencer plus result output register.
//
//   channel  | direction | handshake      | payload
//   in_ch    | in        | valid / ready  | op, effect_id, entity_id, duration
//   out_ch   | out       | valid / ready  | status, top_valid, top_effect_id,
//            |           |                | top_entity_id
//
// Request flow: add and tick go straight to the result read; select scans the
// table one entry per cycle through the shared lateness unit (no scan on an empty
// table); pop moves each entry behind the marked one down one place, each moved entry
// needing a read and a write on the single table memory port pair, and leaves the
// table as it is when nothing is marked.
// Reset (rst_n low at a clock edge) clears time, fill count and the mark at once;
// table contents are left as they are and are never read beyond the fill count.
// A result waits in the output register; the next request is taken meanwhile
// and held in its final state only if the output register is still full.
module overdue_timer_table
  import otm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  otm_in_if.sink     in_ch,
  otm_out_if.source  out_ch
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  // Sequencer owns the request side and all table state.
  otm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register is free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until a new result replaces it.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.top_valid     = out_r.top_valid;
  assign out_ch.top_effect_id = out_r.top_effect_id;
  assign out_ch.top_entity_id = out_r.top_entity_id;

endmodule
